### rtl/ght_pkg.sv
// Package for the generational handle table: field widths, codes, payload and state types.
// Has no dependencies; ght_req_if, ght_rsp_if and generational_handle_table use it, ght_ram does not.
`default_nettype none

package ght_pkg;

    localparam int KIND_W       = 2;
    localparam int HANDLE_W     = 31;
    localparam int DIM_W        = 15;
    localparam int SLOT_FIELD_W = 12;
    localparam int HGEN_W       = HANDLE_W - SLOT_FIELD_W;
    localparam int IDX_W        = SLOT_FIELD_W + 1;
    localparam int ROW_SIZE     = 16;
    localparam int ROW_SHIFT    = 4;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_SIZE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    req_width;
        logic [DIM_W-1:0]    req_height;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] out_handle;
        logic [DIM_W-1:0]    out_width;
        logic [DIM_W-1:0]    out_height;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/ght_req_if.sv
// Request channel of the handle table: valid, ready and one request item.
// Depends on ght_pkg for the payload type.
`default_nettype none

interface ght_req_if;
    logic          valid;
    logic          ready;
    ght_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ght_rsp_if.sv
// Response channel of the handle table: valid, ready and one result item.
// Depends on ght_pkg for the payload type.
`default_nettype none

interface ght_rsp_if;
    logic          valid;
    logic          ready;
    ght_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ght_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                      i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

`default_nettype wire

### rtl/generational_handle_table.sv
// Generational handle table: slots with generation counters that hand out handles.
// Free and query go from idle straight to execution; allocate first passes a look state,
// as the occupancy and slot memories have registered reads. One item at a time; the
// result is registered on commit. Reset clears row flags and the fill count at once;
// memories need no clearing pass and items are accepted right after reset.
// Depends on ght_pkg, ght_req_if, ght_rsp_if and ght_ram.
`default_nettype none

module generational_handle_table #(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 19
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ght_req_if.sink   i_req,
    ght_rsp_if.source o_rsp
);
    import ght_pkg::*;

    localparam int NROWS  = (SLOTS + ROW_SIZE - 1) / ROW_SIZE;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int ENT_W  = GEN_BITS + 2 * DIM_W;
    localparam logic [IDX_W-1:0] SLOTS_L = IDX_W'(SLOTS);

    t_state                  r_state, n_state;
    logic [KIND_W-1:0]       r_kind;
    logic [HGEN_W-1:0]       r_hgen;
    logic                    r_bad_slot;
    logic                    r_size_bad;
    logic                    r_full;
    logic [DIM_W-1:0]        r_w, r_h;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_SHIFT-1:0]    r_bit;
    logic [FILL_W-1:0]       r_fill;
    logic [NROWS-1:0]        r_row_vld;
    logic [NROWS-1:0]        r_row_full;
    logic                    r_out_vld;
    t_rsp                    r_out, n_out;

    logic [ROW_SIZE-1:0]     w_bits;
    logic [ENT_W-1:0]        w_ent;

    logic                    accept;
    logic                    commit;
    logic [IDX_W-1:0]        h_idx;
    logic                    h_bad;
    logic [ROW_W-1:0]        a_row;
    logic                    a_full;
    logic [ROW_SIZE-1:0]     pad;
    logic [ROW_SIZE-1:0]     cur_bits;
    logic [ROW_SIZE-1:0]     one_hot;
    logic [ROW_SHIFT-1:0]    lz;
    logic [IDX_W-1:0]        look_idx;
    logic [IDX_W-1:0]        slot_idx;
    logic [GEN_BITS-1:0]     gen_cur, gen_alloc, gen_next;
    logic                    hok;

    logic                    bm_rd_en, bm_wr_en;
    logic [ROW_W-1:0]        bm_rd_addr;
    logic [ROW_SIZE-1:0]     bm_wr_data;
    logic                    sm_rd_en, sm_wr_en;
    logic [SLOT_W-1:0]       sm_rd_addr;
    logic [ENT_W-1:0]        sm_wr_data;
    logic                    row_full_set, row_full_clr, fill_inc;

    assign accept = i_req.valid && i_req.ready;
    assign commit = (r_state == S_EXEC) && (!r_out_vld || o_rsp.ready);

    assign h_idx = IDX_W'(i_req.data.handle[SLOT_FIELD_W-1:0]) - IDX_W'(1);
    assign h_bad = (i_req.data.handle[SLOT_FIELD_W-1:0] == '0) ||
                   (IDX_W'(i_req.data.handle[SLOT_FIELD_W-1:0]) > SLOTS_L);

    always_comb begin
        a_row  = '0;
        a_full = &r_row_full;
        for (int r = NROWS - 1; r >= 0; r--) begin
            if (!r_row_full[r]) begin
                a_row = ROW_W'(r);
            end
        end
    end

    always_comb begin
        for (int b = 0; b < ROW_SIZE; b++) begin
            pad[b] = ((IDX_W'(r_row) << ROW_SHIFT) + IDX_W'(b)) >= SLOTS_L;
        end
    end

    assign cur_bits = r_row_vld[r_row] ? w_bits : '0;

    always_comb begin
        lz = '0;
        for (int b = ROW_SIZE - 1; b >= 0; b--) begin
            if (!(cur_bits[b] || pad[b])) begin
                lz = ROW_SHIFT'(b);
            end
        end
    end

    assign look_idx = (IDX_W'(r_row) << ROW_SHIFT) | IDX_W'(lz);
    assign slot_idx = (IDX_W'(r_row) << ROW_SHIFT) | IDX_W'(r_bit);
    assign one_hot  = ROW_SIZE'(1) << r_bit;

    assign gen_cur   = (slot_idx < IDX_W'(r_fill)) ? w_ent[ENT_W-1 -: GEN_BITS] : '0;
    assign gen_alloc = (gen_cur == '0) ? GEN_BITS'(1) : gen_cur;
    assign gen_next  = ((gen_cur + GEN_BITS'(1)) == '0) ? GEN_BITS'(1)
                                                        : gen_cur + GEN_BITS'(1);
    assign hok = !r_bad_slot && cur_bits[r_bit] && (HGEN_W'(gen_cur) == r_hgen);

    always_comb begin
        bm_rd_en   = accept;
        bm_rd_addr = (i_req.data.kind == KIND_ALLOC) ? a_row
                                                     : h_idx[ROW_W+ROW_SHIFT-1:ROW_SHIFT];
        sm_rd_en   = accept || (r_state == S_LOOK);
        sm_rd_addr = (r_state == S_LOOK) ? look_idx[SLOT_W-1:0] : h_idx[SLOT_W-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_out        = '{status: ST_BAD_HANDLE, out_handle: '0, out_width: '0,
                         out_height: '0};
        bm_wr_en     = 1'b0;
        bm_wr_data   = cur_bits;
        sm_wr_en     = 1'b0;
        sm_wr_data   = w_ent;
        row_full_set = 1'b0;
        row_full_clr = 1'b0;
        fill_inc     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.data.kind == KIND_ALLOC) ? S_LOOK : S_EXEC;
                end
            end
            S_LOOK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_kind)
                    KIND_ALLOC: begin
                        if (r_size_bad) begin
                            n_out.status = ST_BAD_SIZE;
                        end else if (r_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_out.status     = ST_OK;
                            n_out.out_handle = {HGEN_W'(gen_alloc),
                                                SLOT_FIELD_W'(slot_idx + IDX_W'(1))};
                            bm_wr_en     = 1'b1;
                            bm_wr_data   = cur_bits | one_hot;
                            sm_wr_en     = 1'b1;
                            sm_wr_data   = {gen_alloc, r_w, r_h};
                            row_full_set = &(cur_bits | one_hot | pad);
                            fill_inc     = (slot_idx == IDX_W'(r_fill));
                        end
                    end
                    KIND_FREE: begin
                        if (hok) begin
                            n_out.status = ST_OK;
                            bm_wr_en     = 1'b1;
                            bm_wr_data   = cur_bits & ~one_hot;
                            sm_wr_en     = 1'b1;
                            sm_wr_data   = {gen_next, {(2 * DIM_W){1'b0}}};
                            row_full_clr = 1'b1;
                        end
                    end
                    KIND_QUERY: begin
                        if (hok) begin
                            n_out.status     = ST_OK;
                            n_out.out_width  = w_ent[2*DIM_W-1:DIM_W];
                            n_out.out_height = w_ent[DIM_W-1:0];
                        end
                    end
                    default: begin
                        n_out.status = ST_BAD_HANDLE;
                    end
                endcase
                if (commit) begin
                    n_state = S_IDLE;
                end else begin
                    bm_wr_en = 1'b0;
                    sm_wr_en = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_row_vld  <= '0;
            r_row_full <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (bm_wr_en) begin
                r_row_vld[r_row] <= 1'b1;
            end
            if (commit && (row_full_set || row_full_clr)) begin
                r_row_full[r_row] <= row_full_set;
            end
            if (commit && fill_inc) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_req.data.kind;
            r_hgen     <= i_req.data.handle[HANDLE_W-1:SLOT_FIELD_W];
            r_bad_slot <= h_bad;
            r_size_bad <= (i_req.data.req_width == '0) || (i_req.data.req_height == '0);
            r_full     <= a_full;
            r_w        <= i_req.data.req_width;
            r_h        <= i_req.data.req_height;
            r_row      <= (i_req.data.kind == KIND_ALLOC)
                          ? a_row : h_idx[ROW_W+ROW_SHIFT-1:ROW_SHIFT];
            r_bit      <= h_idx[ROW_SHIFT-1:0];
        end else if (r_state == S_LOOK) begin
            r_bit <= lz;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    ght_ram #(
        .WIDTH (ROW_SIZE),
        .DEPTH (NROWS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (bm_wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (bm_wr_data),
        .i_rd_en   (bm_rd_en),
        .i_rd_addr (bm_rd_addr),
        .o_rd_data (w_bits)
    );

    ght_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (sm_wr_en),
        .i_wr_addr (slot_idx[SLOT_W-1:0]),
        .i_wr_data (sm_wr_data),
        .i_rd_en   (sm_rd_en),
        .i_rd_addr (sm_rd_addr),
        .o_rd_data (w_ent)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(SLOTS))
        else $error("fill count beyond the slot count");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("fill count moved by more than one");

    a_alloc_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.data.out_handle != '0)) |->
        ((o_rsp.data.status == ST_OK) &&
         (o_rsp.data.out_handle[SLOT_FIELD_W-1:0] != '0) &&
         (o_rsp.data.out_handle[HANDLE_W-1:SLOT_FIELD_W] != '0)))
        else $error("returned handle has a zero slot or generation field");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == S_IDLE) && r_out_vld)
        else $error("result not registered after execution");

endmodule

`default_nettype wire
